FILE: design/afk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afk_pkg
// Shared types and constants of the three-joint forward kinematics unit.
// ----------------------------------------------------------------------------
package afk_pkg;

    localparam int TRIG_FRAC_BITS = 16;
    localparam int Q      = 30;                 // series working precision
    localparam int LANES  = 3;                  // t1, t2, t2+t3
    localparam int TERMS  = 6;                  // Horner steps
    localparam int STEP_W = 3;
    localparam int ANG_W  = 17;
    localparam int LEN_W  = 14;
    localparam int POS_W  = 16;
    localparam int TRIG_W = TRIG_FRAC_BITS + 2; // signed sin/cos
    localparam int RND_SH = Q - TRIG_FRAC_BITS;

    localparam logic [Q:0] Q_ONE = (Q+1)'(64'd1 << Q);
    localparam logic [Q:0] RND_HALF = (Q+1)'((64'd1 << RND_SH) >> 1);

    localparam int FULL_TURN    = 36000;
    localparam int QUARTER_TURN = 9000;
    localparam int EIGHTH_TURN  = 4500;
    localparam int ANG_OFFSET   = 4 * FULL_TURN;
    localparam int HALF_DEG     = 18000;

    localparam logic [63:0] PI_Q48     = 64'h3243F6A8885A3;
    localparam logic [35:0] RAD_QUO    = 36'(PI_Q48 / HALF_DEG);
    localparam logic [14:0] RAD_REM    = 15'(PI_Q48 % HALF_DEG);
    localparam logic [16:0] TURN_RECIP = 17'((64'd1 << 32) / FULL_TURN);
    localparam logic [17:0] RAD_RECIP  = 18'((64'd1 << 32) / HALF_DEG);

    localparam logic [7:0] SIN_DIV [TERMS] = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0] COS_DIV [TERMS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [31:0] SIN_RECIP [TERMS] = '{
        32'((64'd1 << 32) / 156), 32'((64'd1 << 32) / 110), 32'((64'd1 << 32) / 72),
        32'((64'd1 << 32) / 42),  32'((64'd1 << 32) / 20),  32'((64'd1 << 32) / 6)};
    localparam logic [31:0] COS_RECIP [TERMS] = '{
        32'((64'd1 << 32) / 132), 32'((64'd1 << 32) / 90), 32'((64'd1 << 32) / 56),
        32'((64'd1 << 32) / 30),  32'((64'd1 << 32) / 12), 32'((64'd1 << 32) / 2)};

    localparam int XY_MAX = 20000;
    localparam int Z_MAX  = 30000;
    localparam int Z_MIN  = 20000;   // magnitude of the low limit

    typedef enum logic [1:0] {
        CFG_BASE_HEIGHT = 2'd0,
        CFG_UPPER_LINK  = 2'd1,
        CFG_FORE_LINK   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [Q-1:0] x;
        logic [Q-1:0] x2;
        logic [Q:0]   ts;
        logic [Q:0]   tc;
        logic         swap;
        logic [1:0]   quad;
    } t_lane;
    typedef t_lane [LANES-1:0] t_lanes;

    typedef struct packed {
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] c;
    } t_trig;
    typedef t_trig [LANES-1:0] t_trigs;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } t_pos;

endpackage

FILE: design/afk_angle_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afk_angle_prep
// Wraps each angle to one octant and converts it to Q30 radians and x^2.
// ----------------------------------------------------------------------------
module afk_angle_prep (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [afk_pkg::ANG_W-1:0] i_base_angle,
    input  logic signed [afk_pkg::ANG_W-1:0] i_shoulder_angle,
    input  logic signed [afk_pkg::ANG_W-1:0] i_elbow_angle,
    output logic                         o_valid,
    output afk_pkg::t_lanes              o_lanes
);
    localparam int L = afk_pkg::LANES;
    localparam int Q = afk_pkg::Q;

    logic [5:0] r_vld;

    logic [18:0] r1_v  [L];
    logic [35:0] r1_qp [L];
    logic [12:0] r2_b  [L];
    logic        r2_swap [L];
    logic [1:0]  r2_quad [L];
    logic [47:0] r3_bq [L];
    logic [26:0] r3_m  [L];
    logic        r3_swap [L];
    logic [1:0]  r3_quad [L];
    logic [47:0] r4_bq [L];
    logic [26:0] r4_m  [L];
    logic [44:0] r4_mp [L];
    logic        r4_swap [L];
    logic [1:0]  r4_quad [L];
    logic [Q-1:0] r5_x [L];
    logic        r5_swap [L];
    logic [1:0]  r5_quad [L];
    afk_pkg::t_lanes r6_lanes;

    logic [18:0] n1_v  [L];
    logic [12:0] n2_b  [L];
    logic        n2_swap [L];
    logic [1:0]  n2_quad [L];
    logic [Q-1:0] n5_x [L];

    always_comb begin
        logic signed [19:0] ang [L];
        logic [2:0]  q;
        logic [18:0] rem;
        logic [15:0] r;
        logic [12:0] qf;
        logic [26:0] mr;
        logic [48:0] sum;
        ang[0] = 20'(i_base_angle);
        ang[1] = 20'(i_shoulder_angle);
        ang[2] = 20'(i_shoulder_angle) + 20'(i_elbow_angle);
        for (int j = 0; j < L; j++) begin
            n1_v[j] = 19'(ang[j] + 20'(afk_pkg::ANG_OFFSET));
            // modulo one turn: reciprocal estimate, one fixup
            q   = r1_qp[j][34:32];
            rem = r1_v[j] - 19'(19'(q) * 19'(afk_pkg::FULL_TURN));
            if (rem >= 19'(afk_pkg::FULL_TURN)) begin
                rem = rem - 19'(afk_pkg::FULL_TURN);
            end
            if (rem >= 19'(3 * afk_pkg::QUARTER_TURN)) begin
                n2_quad[j] = 2'd3;
                r = 16'(rem - 19'(3 * afk_pkg::QUARTER_TURN));
            end else if (rem >= 19'(2 * afk_pkg::QUARTER_TURN)) begin
                n2_quad[j] = 2'd2;
                r = 16'(rem - 19'(2 * afk_pkg::QUARTER_TURN));
            end else if (rem >= 19'(afk_pkg::QUARTER_TURN)) begin
                n2_quad[j] = 2'd1;
                r = 16'(rem - 19'(afk_pkg::QUARTER_TURN));
            end else begin
                n2_quad[j] = 2'd0;
                r = 16'(rem);
            end
            n2_swap[j] = (r > 16'(afk_pkg::EIGHTH_TURN));
            n2_b[j]    = n2_swap[j] ? 13'(16'(afk_pkg::QUARTER_TURN) - r) : 13'(r);
            // b*pi/18000 split into quotient and remainder parts
            qf = 13'(r4_mp[j] >> 32);
            mr = r4_m[j] - 27'(27'(qf) * 27'(afk_pkg::HALF_DEG));
            if (mr >= 27'(afk_pkg::HALF_DEG)) begin
                qf = qf + 13'd1;
            end
            sum = 49'(r4_bq[j]) + 49'(qf) + 49'(64'd1 << 17);
            n5_x[j] = Q'(sum >> 18);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < L; j++) begin
                r1_v[j]    <= n1_v[j];
                r1_qp[j]   <= 36'(n1_v[j]) * 36'(afk_pkg::TURN_RECIP);
                r2_b[j]    <= n2_b[j];
                r2_swap[j] <= n2_swap[j];
                r2_quad[j] <= n2_quad[j];
                r3_bq[j]   <= 48'(48'(r2_b[j]) * 48'(afk_pkg::RAD_QUO));
                r3_m[j]    <= 27'(r2_b[j]) * 27'(afk_pkg::RAD_REM);
                r3_swap[j] <= r2_swap[j];
                r3_quad[j] <= r2_quad[j];
                r4_bq[j]   <= r3_bq[j];
                r4_m[j]    <= r3_m[j];
                r4_mp[j]   <= 45'(r3_m[j]) * 45'(afk_pkg::RAD_RECIP);
                r4_swap[j] <= r3_swap[j];
                r4_quad[j] <= r3_quad[j];
                r5_x[j]    <= n5_x[j];
                r5_swap[j] <= r4_swap[j];
                r5_quad[j] <= r4_quad[j];
                r6_lanes[j].x    <= r5_x[j];
                r6_lanes[j].x2   <= Q'(((2*Q)'(r5_x[j]) * (2*Q)'(r5_x[j])) >> Q);
                r6_lanes[j].ts   <= afk_pkg::Q_ONE;
                r6_lanes[j].tc   <= afk_pkg::Q_ONE;
                r6_lanes[j].swap <= r5_swap[j];
                r6_lanes[j].quad <= r5_quad[j];
            end
        end
    end

    assign o_valid = r_vld[5];
    assign o_lanes = r6_lanes;

endmodule

FILE: design/afk_series_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afk_series_cell
// One Horner step of the sine and cosine series: t = 1 - (x^2 * t) / d.
// ----------------------------------------------------------------------------
module afk_series_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic [afk_pkg::STEP_W-1:0]         i_step,
    input  logic                               i_valid,
    input  afk_pkg::t_lanes                    i_lanes,
    output logic                               o_valid,
    output afk_pkg::t_lanes                    o_lanes
);
    localparam int L = afk_pkg::LANES;
    localparam int Q = afk_pkg::Q;

    logic [2:0]       r_vld;
    afk_pkg::t_lanes  r1_lanes, r2_lanes, r3_lanes;
    logic [Q-1:0]     r1_ps [L];
    logic [Q-1:0]     r1_pc [L];
    logic [Q-1:0]     r2_ps [L];
    logic [Q-1:0]     r2_pc [L];
    logic [61:0]      r2_es [L];
    logic [61:0]      r2_ec [L];
    afk_pkg::t_lanes  n3_lanes;

    // quotient from reciprocal estimate, at most one low
    function automatic logic [Q:0] afk_step_div(input logic [Q-1:0] p,
                                                input logic [61:0] e,
                                                input logic [7:0] d);
        logic [Q-1:0] qe;
        logic [Q-1:0] rm;
        qe = Q'(e >> 32);
        rm = p - Q'(Q'(qe) * Q'(d));
        if (rm >= Q'(d)) begin
            qe = qe + Q'(1);
        end
        return afk_pkg::Q_ONE - (Q+1)'(qe);
    endfunction

    always_comb begin
        for (int j = 0; j < L; j++) begin
            n3_lanes[j]    = r2_lanes[j];
            n3_lanes[j].ts = afk_step_div(r2_ps[j], r2_es[j], afk_pkg::SIN_DIV[i_step]);
            n3_lanes[j].tc = afk_step_div(r2_pc[j], r2_ec[j], afk_pkg::COS_DIV[i_step]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_lanes <= i_lanes;
            r2_lanes <= r1_lanes;
            r3_lanes <= n3_lanes;
            for (int j = 0; j < L; j++) begin
                r1_ps[j] <= Q'(((2*Q+1)'(i_lanes[j].x2) * (2*Q+1)'(i_lanes[j].ts)) >> Q);
                r1_pc[j] <= Q'(((2*Q+1)'(i_lanes[j].x2) * (2*Q+1)'(i_lanes[j].tc)) >> Q);
                r2_ps[j] <= r1_ps[j];
                r2_pc[j] <= r1_pc[j];
                r2_es[j] <= 62'(r1_ps[j]) * 62'(afk_pkg::SIN_RECIP[i_step]);
                r2_ec[j] <= 62'(r1_pc[j]) * 62'(afk_pkg::COS_RECIP[i_step]);
            end
        end
    end

    assign o_valid = r_vld[2];
    assign o_lanes = r3_lanes;

endmodule

FILE: design/afk_trig_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afk_trig_out
// Finishes the series, rounds to the trig fraction and undoes the octant swap and the quadrant.
// ----------------------------------------------------------------------------
module afk_trig_out (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  afk_pkg::t_lanes  i_lanes,
    output logic             o_valid,
    output afk_pkg::t_trigs  o_trig
);
    localparam int L  = afk_pkg::LANES;
    localparam int Q  = afk_pkg::Q;
    localparam int TW = afk_pkg::TRIG_W;

    logic [1:0]       r_vld;
    logic [Q-1:0]     r1_sq [L];
    logic [Q:0]       r1_tc [L];
    logic             r1_swap [L];
    logic [1:0]       r1_quad [L];
    afk_pkg::t_trigs  r2_trig;
    afk_pkg::t_trigs  n2_trig;

    always_comb begin
        logic signed [TW-1:0] s0;
        logic signed [TW-1:0] c0;
        logic signed [TW-1:0] tmp;
        for (int j = 0; j < L; j++) begin
            s0 = TW'(((Q+1)'(r1_sq[j]) + afk_pkg::RND_HALF) >> afk_pkg::RND_SH);
            c0 = TW'((r1_tc[j] + afk_pkg::RND_HALF) >> afk_pkg::RND_SH);
            if (r1_swap[j]) begin
                tmp = s0;
                s0  = c0;
                c0  = tmp;
            end
            case (r1_quad[j])
                2'd0: begin
                    n2_trig[j].s = s0;
                    n2_trig[j].c = c0;
                end
                2'd1: begin
                    n2_trig[j].s = c0;
                    n2_trig[j].c = -s0;
                end
                2'd2: begin
                    n2_trig[j].s = -s0;
                    n2_trig[j].c = -c0;
                end
                default: begin
                    n2_trig[j].s = -c0;
                    n2_trig[j].c = s0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_trig <= n2_trig;
            for (int j = 0; j < L; j++) begin
                r1_sq[j]   <= Q'(((2*Q+1)'(i_lanes[j].x) * (2*Q+1)'(i_lanes[j].ts)) >> Q);
                r1_tc[j]   <= i_lanes[j].tc;
                r1_swap[j] <= i_lanes[j].swap;
                r1_quad[j] <= i_lanes[j].quad;
            end
        end
    end

    assign o_valid = r_vld[1];
    assign o_trig  = r2_trig;

endmodule

FILE: design/arm_forward_kinematics_3dof_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_forward_kinematics_3dof_unit
// End point of a three-joint arm from its joint angles (DH chain, position).
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  input    | i_valid / o_stall         | i_base_angle, i_shoulder_angle,
//           |                           | i_elbow_angle (s17, 0.01 deg)
//  output   | o_valid / i_stall         | o_pos_x, o_pos_y, o_pos_z (s16)
//  config   | i_cfg_we, i_cfg_addr      | i_cfg_data (u14)
//
//  One item per cycle while o_stall is low. From acceptance to o_valid an
//  item passes 6 angle-prep stages, 6 series cells of 3 stages, 2 trig
//  finishing stages and 4 stages of link math, plus the output register.
//  The series cells form a chain; each cell owns one Horner term and hands
//  its partial sums to the next cell every cycle unless the pipe holds.
//  Synchronous active-low reset clears valids and sets the link registers
//  to their defaults. A two-entry output (register plus skid) lets the
//  pipe keep taking items while a result waits; o_stall rises only once
//  the skid entry is full, and the whole pipe then holds.
// ----------------------------------------------------------------------------
module arm_forward_kinematics_3dof_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [afk_pkg::ANG_W-1:0]   i_base_angle,
    input  logic signed [afk_pkg::ANG_W-1:0]   i_shoulder_angle,
    input  logic signed [afk_pkg::ANG_W-1:0]   i_elbow_angle,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [afk_pkg::POS_W-1:0]   o_pos_x,
    output logic signed [afk_pkg::POS_W-1:0]   o_pos_y,
    output logic signed [afk_pkg::POS_W-1:0]   o_pos_z,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_addr,
    input  logic [afk_pkg::LEN_W-1:0]          i_cfg_data
);
    localparam int F   = afk_pkg::TRIG_FRAC_BITS;
    localparam int TW  = afk_pkg::TRIG_W;
    localparam int LW  = afk_pkg::LEN_W;
    localparam int PW  = LW + TW + 1;      // length * trig
    localparam int ZW  = PW + 2;           // z accumulation
    localparam int MW  = PW + TW;          // |r| * |trig|
    localparam int T   = afk_pkg::TERMS;

    // link registers
    logic [LW-1:0] r_d1, r_a2, r_a3;

    // global advance: the pipe holds only while the skid entry is full
    logic r_skid_valid;
    logic pipe_en;
    assign pipe_en = !r_skid_valid;
    assign o_stall = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= LW'(500);
            r_a2 <= LW'(300);
            r_a3 <= LW'(200);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                afk_pkg::CFG_BASE_HEIGHT: r_d1 <= i_cfg_data;
                afk_pkg::CFG_UPPER_LINK:  r_a2 <= i_cfg_data;
                afk_pkg::CFG_FORE_LINK:   r_a3 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // angle preparation
    logic            prep_valid;
    afk_pkg::t_lanes prep_lanes;

    afk_angle_prep u_prep (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (pipe_en),
        .i_valid          (i_valid),
        .i_base_angle     (i_base_angle),
        .i_shoulder_angle (i_shoulder_angle),
        .i_elbow_angle    (i_elbow_angle),
        .o_valid          (prep_valid),
        .o_lanes          (prep_lanes)
    );

    // chain of series cells, one Horner term each
    logic            cell_valid [T+1];
    afk_pkg::t_lanes cell_lanes [T+1];
    assign cell_valid[0] = prep_valid;
    assign cell_lanes[0] = prep_lanes;

    for (genvar k = 0; k < T; k++) begin : g_cell
        afk_series_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pipe_en),
            .i_step  (afk_pkg::STEP_W'(k)),
            .i_valid (cell_valid[k]),
            .i_lanes (cell_lanes[k]),
            .o_valid (cell_valid[k+1]),
            .o_lanes (cell_lanes[k+1])
        );
    end

    logic            trig_valid;
    afk_pkg::t_trigs trig;

    afk_trig_out u_trig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_valid (cell_valid[T]),
        .i_lanes (cell_lanes[T]),
        .o_valid (trig_valid),
        .o_trig  (trig)
    );

    // link math: lane 0 is t1, lane 1 is t2, lane 2 is t2+t3
    logic [3:0]              r_bvld;
    logic signed [PW-1:0]    r1_p2c, r1_p3c, r1_p2s, r1_p3s;
    afk_pkg::t_trig          r1_t1, r2_t1;
    logic signed [PW:0]      r2_r;
    logic signed [ZW-1:0]    r2_zq;
    logic [MW-1:0]           r3_px, r3_py;
    logic                    r3_xneg, r3_yneg;
    logic signed [afk_pkg::POS_W-1:0] r3_z;
    afk_pkg::t_pos           r4_pos;

    logic [PW:0]             rmag;
    logic [TW-1:0]           cmag, smag;
    logic [ZW-1:0]           zmag;
    logic [ZW-1:0]           zm;
    logic signed [afk_pkg::POS_W-1:0] n3_z;
    afk_pkg::t_pos           n4_pos;

    // rounded product magnitude: ((|r|*|t| >> 2F-1) + 1) >> 1, saturated
    function automatic logic signed [afk_pkg::POS_W-1:0] afk_round_xy(
            input logic [MW-1:0] p, input logic neg);
        logic [MW-1:0] m;
        m = ((p >> (2*F-1)) + MW'(1)) >> 1;
        if (m > MW'(afk_pkg::XY_MAX)) begin
            m = MW'(afk_pkg::XY_MAX);
        end
        return neg ? -afk_pkg::POS_W'(m) : afk_pkg::POS_W'(m);
    endfunction

    always_comb begin
        rmag = r2_r[PW] ? (PW+1)'(-r2_r) : (PW+1)'(r2_r);
        cmag = r2_t1.c[TW-1] ? TW'(-r2_t1.c) : TW'(r2_t1.c);
        smag = r2_t1.s[TW-1] ? TW'(-r2_t1.s) : TW'(r2_t1.s);
        zmag = r2_zq[ZW-1] ? ZW'(-r2_zq) : ZW'(r2_zq);
        zm   = (zmag + ZW'(64'd1 << (F-1))) >> F;
        if (r2_zq[ZW-1]) begin
            n3_z = (zm > ZW'(afk_pkg::Z_MIN)) ? -afk_pkg::POS_W'(afk_pkg::Z_MIN)
                                               : -afk_pkg::POS_W'(zm);
        end else begin
            n3_z = (zm > ZW'(afk_pkg::Z_MAX)) ? afk_pkg::POS_W'(afk_pkg::Z_MAX)
                                               : afk_pkg::POS_W'(zm);
        end
        n4_pos.x = afk_round_xy(r3_px, r3_xneg);
        n4_pos.y = afk_round_xy(r3_py, r3_yneg);
        n4_pos.z = r3_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvld <= '0;
        end else if (pipe_en) begin
            r_bvld <= {r_bvld[2:0], trig_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r1_p2c <= PW'($signed({1'b0, r_a2}) * trig[1].c);
            r1_p3c <= PW'($signed({1'b0, r_a3}) * trig[2].c);
            r1_p2s <= PW'($signed({1'b0, r_a2}) * trig[1].s);
            r1_p3s <= PW'($signed({1'b0, r_a3}) * trig[2].s);
            r1_t1  <= trig[0];
            r2_t1  <= r1_t1;
            r2_r   <= (PW+1)'(r1_p2c) + (PW+1)'(r1_p3c);
            r2_zq  <= $signed(ZW'({r_d1, F'(0)})) + ZW'(r1_p2s) + ZW'(r1_p3s);
            r3_px  <= MW'(rmag) * MW'(cmag);
            r3_py  <= MW'(rmag) * MW'(smag);
            r3_xneg <= r2_t1.c[TW-1] != r2_r[PW];
            r3_yneg <= r2_t1.s[TW-1] != r2_r[PW];
            r3_z   <= n3_z;
            r4_pos <= n4_pos;
        end
    end

    // output register with skid entry
    logic          arrive;
    logic          out_free;
    logic          r_out_valid;
    afk_pkg::t_pos r_out, r_skid;

    assign arrive   = r_bvld[3] && pipe_en;
    assign out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_free) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (arrive) begin
            if (out_free) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_free) begin
                r_out <= r_skid;
            end
        end else if (arrive) begin
            if (out_free) begin
                r_out <= r4_pos;
            end else begin
                r_skid <= r4_pos;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_pos_x = r_out.x;
    assign o_pos_y = r_out.y;
    assign o_pos_z = r_out.z;

endmodule

FILE: design/afk_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afk_checker
// Port-level checks of the forward kinematics unit, bound to the top level.
// ----------------------------------------------------------------------------
module afk_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               o_stall,
    input  logic                               o_valid,
    input  logic                               i_stall,
    input  logic signed [afk_pkg::POS_W-1:0]   o_pos_x,
    input  logic signed [afk_pkg::POS_W-1:0]   o_pos_y,
    input  logic signed [afk_pkg::POS_W-1:0]   o_pos_z
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs not idle after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_pos_x) && $stable(o_pos_y) &&
                               $stable(o_pos_z))
        else $error("stalled item changed");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_pos_x >= -16'sd20000 && o_pos_x <= 16'sd20000 &&
                    o_pos_y >= -16'sd20000 && o_pos_y <= 16'sd20000 &&
                    o_pos_z >= -16'sd20000 && o_pos_z <= 16'sd30000)
        else $error("position out of range");

endmodule

bind arm_forward_kinematics_3dof_unit afk_checker u_afk_checker (.*);
